>>> rtl/pnal_pkg.sv
`timescale 1ns / 1ps
// pnal_pkg: shared types and codes for the polyline nearest arc length core
// holds the controller/datapath command and status structs; no dependencies

package pnal_pkg;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam int AlphaOne = 65536;
	localparam int RoundHalf = 32768;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_SQ_CA,
		MUL_DE,
		MUL_DD,
		MUL_DA,
		MUL_PP,
		MUL_SEG
	} mul_op_t;

	typedef enum logic [1:0] {
		ADDR_IDX,
		ADDR_IDX1,
		ADDR_LAST,
		ADDR_ZERO
	} addr_sel_t;

	typedef struct packed {
		logic       capture;
		logic       restart_clr;
		logic       rd;
		addr_sel_t  addr;
		logic       lat_a;
		logic       lat_b;
		logic       acc_clr;
		logic       dist_clr;
		mul_op_t    mul;
		logic [1:0] k;
		logic       sq_init;
		logic       sq_step;
		logic       div_init;
		logic       div_step;
		logic       best_load;
		logic       s_init;
		logic       idx_clr;
		logic       idx_inc;
		logic       wr;
		logic       emit;
		logic       emit_arc;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic cnt_zero;
		logic cnt_full;
		logic seg_last;
		logic div_need;
		logic dist_lt;
	} sts_t;

endpackage

>>> rtl/pnal_item_if.sv
`timescale 1ns / 1ps
// pnal_item_if: request channel carrying load and query items
// valid/ready handshake; no dependencies

interface pnal_item_if #(
	parameter int COORD_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic                          restart;
	logic signed [COORD_WIDTH-1:0] x;
	logic signed [COORD_WIDTH-1:0] y;
	logic signed [COORD_WIDTH-1:0] z;

	modport source (output valid, kind, restart, x, y, z, input ready);
	modport sink (input valid, kind, restart, x, y, z, output ready);
endinterface

>>> rtl/pnal_result_if.sv
`timescale 1ns / 1ps
// pnal_result_if: result channel carrying arc length and status
// valid/ready handshake; no dependencies

interface pnal_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] arc_length;
	logic [1:0]  status;

	modport source (output valid, arc_length, status, input ready);
	modport sink (input valid, arc_length, status, output ready);
endinterface

>>> rtl/pnal_ctrl.sv
`timescale 1ns / 1ps
// pnal_ctrl: sequencer issuing datapath commands per request
// depends on pnal_pkg

module pnal_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  logic          result_ready,
	output logic          result_valid,
	input  pnal_pkg::sts_t sts,
	output pnal_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISP,
		ST_L_CHK, ST_L_LAT, ST_L_MUL, ST_L_WAIT, ST_L_SQI, ST_L_SQ, ST_L_WR,
		ST_Q_CHK, ST_Q_LAT, ST_Q_MUL, ST_Q_WAIT, ST_Q_BEST,
		ST_SEG_CHK, ST_S_RA, ST_S_RB, ST_S_DE, ST_S_DD, ST_S_WAIT,
		ST_S_DIVI, ST_S_DIV, ST_S_DA, ST_S_PP, ST_S_W2, ST_S_CMP,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic [1:0] k_q;
	logic [4:0] n_q;
	logic [1:0] code_q;
	logic       arc_q;
	logic       out_valid_q;
	logic       emit_ok;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign emit_ok      = !out_valid_q || result_ready;

	always_comb begin
		cmd = '0;
		cmd.k = k_q;
		case (state_q)
			ST_IDLE: cmd.capture = item_valid;
			ST_DISP: cmd.restart_clr = !sts.kind;
			ST_L_CHK: begin
				if (!sts.cnt_full && sts.cnt_zero) begin
					cmd.wr = 1'b1;
				end else if (!sts.cnt_full) begin
					cmd.rd = 1'b1;
					cmd.addr = pnal_pkg::ADDR_LAST;
					cmd.acc_clr = 1'b1;
				end
			end
			ST_L_LAT: cmd.lat_a = 1'b1;
			ST_L_MUL: cmd.mul = pnal_pkg::MUL_SQ_CA;
			ST_L_SQI: cmd.sq_init = 1'b1;
			ST_L_SQ: cmd.sq_step = 1'b1;
			ST_L_WR: cmd.wr = 1'b1;
			ST_Q_CHK: begin
				if (!sts.cnt_zero) begin
					cmd.rd = 1'b1;
					cmd.addr = pnal_pkg::ADDR_ZERO;
					cmd.idx_clr = 1'b1;
					cmd.acc_clr = 1'b1;
					cmd.s_init = 1'b1;
				end
			end
			ST_Q_LAT: cmd.lat_a = 1'b1;
			ST_Q_MUL: cmd.mul = pnal_pkg::MUL_SQ_CA;
			ST_Q_BEST: cmd.best_load = 1'b1;
			ST_SEG_CHK: begin
				if (!sts.seg_last) begin
					cmd.rd = 1'b1;
					cmd.addr = pnal_pkg::ADDR_IDX;
					cmd.acc_clr = 1'b1;
				end
			end
			ST_S_RA: begin
				cmd.lat_a = 1'b1;
				cmd.rd = 1'b1;
				cmd.addr = pnal_pkg::ADDR_IDX1;
			end
			ST_S_RB: cmd.lat_b = 1'b1;
			ST_S_DE: cmd.mul = pnal_pkg::MUL_DE;
			ST_S_DD: cmd.mul = pnal_pkg::MUL_DD;
			ST_S_DIVI: begin
				cmd.div_init = 1'b1;
				cmd.dist_clr = 1'b1;
			end
			ST_S_DIV: cmd.div_step = sts.div_need;
			ST_S_DA: cmd.mul = pnal_pkg::MUL_DA;
			ST_S_PP: cmd.mul = pnal_pkg::MUL_PP;
			ST_S_CMP: begin
				cmd.idx_inc = 1'b1;
				if (sts.dist_lt) begin
					cmd.best_load = 1'b1;
					cmd.mul = pnal_pkg::MUL_SEG;
				end
			end
			ST_EMIT: begin
				cmd.emit = emit_ok;
				cmd.emit_arc = arc_q;
				cmd.code = code_q;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			n_q <= '0;
			code_q <= pnal_pkg::STATUS_OK;
			arc_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (item_valid) state_q <= ST_DISP;
				ST_DISP: state_q <= sts.kind ? ST_Q_CHK : ST_L_CHK;
				ST_L_CHK: begin
					code_q <= sts.cnt_full ? pnal_pkg::STATUS_FULL : pnal_pkg::STATUS_OK;
					arc_q <= 1'b0;
					state_q <= (sts.cnt_full || sts.cnt_zero) ? ST_EMIT : ST_L_LAT;
				end
				ST_L_LAT: begin
					k_q <= '0;
					state_q <= ST_L_MUL;
				end
				ST_L_MUL: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					if (k_q == 2'd2) state_q <= ST_L_WAIT;
				end
				ST_L_WAIT: state_q <= ST_L_SQI;
				ST_L_SQI: begin
					n_q <= '0;
					state_q <= ST_L_SQ;
				end
				ST_L_SQ: begin
					n_q <= n_q + 5'd1;
					if (n_q == 5'd31) state_q <= ST_L_WR;
				end
				ST_L_WR: state_q <= ST_EMIT;
				ST_Q_CHK: begin
					code_q <= sts.cnt_zero ? pnal_pkg::STATUS_EMPTY : pnal_pkg::STATUS_OK;
					arc_q <= !sts.cnt_zero;
					state_q <= sts.cnt_zero ? ST_EMIT : ST_Q_LAT;
				end
				ST_Q_LAT: begin
					k_q <= '0;
					state_q <= ST_Q_MUL;
				end
				ST_Q_MUL: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					if (k_q == 2'd2) state_q <= ST_Q_WAIT;
				end
				ST_Q_WAIT: state_q <= ST_Q_BEST;
				ST_Q_BEST: state_q <= ST_SEG_CHK;
				ST_SEG_CHK: state_q <= sts.seg_last ? ST_EMIT : ST_S_RA;
				ST_S_RA: state_q <= ST_S_RB;
				ST_S_RB: begin
					k_q <= '0;
					state_q <= ST_S_DE;
				end
				ST_S_DE: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					if (k_q == 2'd2) state_q <= ST_S_DD;
				end
				ST_S_DD: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					if (k_q == 2'd2) state_q <= ST_S_WAIT;
				end
				ST_S_WAIT: state_q <= ST_S_DIVI;
				ST_S_DIVI: begin
					n_q <= '0;
					state_q <= ST_S_DIV;
				end
				ST_S_DIV: begin
					n_q <= n_q + 5'd1;
					if (!sts.div_need || n_q == 5'd15) state_q <= ST_S_DA;
				end
				ST_S_DA: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					if (k_q == 2'd2) state_q <= ST_S_PP;
				end
				ST_S_PP: begin
					k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					if (k_q == 2'd2) state_q <= ST_S_W2;
				end
				ST_S_W2: state_q <= ST_S_CMP;
				ST_S_CMP: state_q <= ST_SEG_CHK;
				ST_EMIT: if (emit_ok) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/pnal_dp.sv
`timescale 1ns / 1ps
// pnal_dp: point and length memories, shared multiplier, divider and square root
// depends on pnal_pkg

module pnal_dp #(
	parameter int MAX_POINTS  = 256,
	parameter int COORD_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          kind,
	input  logic                          restart,
	input  logic signed [COORD_WIDTH-1:0] x,
	input  logic signed [COORD_WIDTH-1:0] y,
	input  logic signed [COORD_WIDTH-1:0] z,
	input  pnal_pkg::cmd_t                cmd,
	output pnal_pkg::sts_t                sts,
	output logic [31:0]                   arc_length,
	output logic [1:0]                    status
);

	localparam int CW   = COORD_WIDTH;
	localparam int DW   = CW + 1;
	localparam int MW   = (CW + 2 > 33) ? CW + 2 : 33;
	localparam int PW   = 2 * MW;
	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNW  = AW + 1;

	logic [3*CW-1:0] pt_mem [MAX_POINTS];
	logic [31:0]     cum_mem [MAX_POINTS];
	logic [3*CW-1:0] pt_rd_q;
	logic [31:0]     cum_rd_q;

	logic signed [CW-1:0] c_q [3];
	logic signed [CW-1:0] a_q [3];
	logic signed [CW-1:0] b_q [3];
	logic [31:0]          cuma_q, cumb_q;
	logic                 kind_q, restart_q;
	logic [CNW-1:0]       cnt_q;
	logic [AW-1:0]        idx_q;
	logic [31:0]          total_q, s_q;
	logic [63:0]          pos_q, neg_q, den_q, dist_q, best_q;
	logic [63:0]          rem_q, sq_v_q, sq_res_q, sq_bit_q;
	logic [15:0]          quo_q;
	logic [16:0]          al_q;
	logic                 div_need_q;
	logic [MW-1:0]        pm_q [3];
	logic [31:0]          out_arc_q;
	logic [1:0]           out_status_q;

	logic [PW-1:0]        prod_s1;
	pnal_pkg::mul_op_t    op_s1;
	logic [1:0]           k_s1;
	logic                 neg_s1;

	logic signed [CW:0]   d [3];
	logic signed [CW:0]   e [3];
	logic [CW:0]          dm [3];
	logic [CW:0]          em [3];
	logic [MW-1:0]        ma, mb;
	logic                 prod_neg;
	logic [AW-1:0]        rd_addr;

	logic [PW-1:0]        rnd;
	logic [CW:0]          r;
	logic signed [CW+2:0] pv, ev;
	logic [CW+2:0]        evm;
	logic [31:0]          cumv;
	logic [32:0]          lsum;
	logic [63:0]          num, rem2, sq_t;
	logic [15:0]          quo_n;

	assign arc_length = out_arc_q;
	assign status     = out_status_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d[k]  = DW'(b_q[k]) - DW'(a_q[k]);
			e[k]  = DW'(c_q[k]) - DW'(a_q[k]);
			dm[k] = d[k][CW] ? DW'(-d[k]) : DW'(d[k]);
			em[k] = e[k][CW] ? DW'(-e[k]) : DW'(e[k]);
		end
	end

	always_comb begin
		ma = '0;
		mb = '0;
		prod_neg = d[cmd.k][CW] ^ e[cmd.k][CW];
		case (cmd.mul)
			pnal_pkg::MUL_SQ_CA: begin
				ma = MW'(em[cmd.k]);
				mb = MW'(em[cmd.k]);
			end
			pnal_pkg::MUL_DE: begin
				ma = MW'(dm[cmd.k]);
				mb = MW'(em[cmd.k]);
			end
			pnal_pkg::MUL_DD: begin
				ma = MW'(dm[cmd.k]);
				mb = MW'(dm[cmd.k]);
			end
			pnal_pkg::MUL_DA: begin
				ma = MW'(dm[cmd.k]);
				mb = MW'(al_q);
			end
			pnal_pkg::MUL_PP: begin
				ma = pm_q[cmd.k];
				mb = pm_q[cmd.k];
			end
			pnal_pkg::MUL_SEG: begin
				ma = MW'(cumb_q - cuma_q);
				mb = MW'(al_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		case (cmd.addr)
			pnal_pkg::ADDR_IDX:  rd_addr = idx_q;
			pnal_pkg::ADDR_IDX1: rd_addr = idx_q + AW'(1);
			pnal_pkg::ADDR_LAST: rd_addr = AW'(cnt_q - CNW'(1));
			default:             rd_addr = '0;
		endcase
	end

	// rounding, projection, second stage of the multiplier, cumulative length, divider and square root terms
	always_comb begin
		rnd  = prod_s1 + PW'(pnal_pkg::RoundHalf);
		r    = rnd[16 +: DW];
		pv   = (CW+3)'(a_q[k_s1]) + (d[k_s1][CW] ? -signed'({2'b00, r}) : signed'({2'b00, r}));
		ev   = (CW+3)'(c_q[k_s1]) - pv;
		evm  = ev[CW+2] ? unsigned'(-ev) : unsigned'(ev);
		lsum = {1'b0, cuma_q} + {1'b0, sq_res_q[31:0]};
		cumv = (cnt_q == '0) ? 32'd0 : (lsum[32] ? 32'hFFFF_FFFF : lsum[31:0]);
		num  = pos_q - neg_q;
		rem2 = rem_q << 1;
		quo_n = {quo_q[14:0], rem2 >= den_q};
		sq_t = sq_res_q + sq_bit_q;
	end

	assign sts.kind     = kind_q;
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.cnt_full = (cnt_q >= CNW'(MAX_POINTS));
	assign sts.seg_last = (CNW'(idx_q) + CNW'(1)) >= cnt_q;
	assign sts.div_need = div_need_q;
	assign sts.dist_lt  = dist_q < best_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			pt_mem[cnt_q[AW-1:0]] <= {c_q[2], c_q[1], c_q[0]};
			cum_mem[cnt_q[AW-1:0]] <= cumv;
		end
		if (cmd.rd) begin
			pt_rd_q <= pt_mem[rd_addr];
			cum_rd_q <= cum_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			total_q <= '0;
			op_s1 <= pnal_pkg::MUL_NONE;
		end else begin
			op_s1 <= cmd.mul;
			if (cmd.restart_clr && restart_q) begin
				cnt_q <= '0;
				total_q <= '0;
			end else if (cmd.wr) begin
				cnt_q <= cnt_q + CNW'(1);
				total_q <= cumv;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(ma) * PW'(mb);
		k_s1 <= cmd.k;
		neg_s1 <= prod_neg;
		if (cmd.capture) begin
			c_q[0] <= x;
			c_q[1] <= y;
			c_q[2] <= z;
			kind_q <= kind;
			restart_q <= restart;
		end
		if (cmd.lat_a) begin
			for (int k = 0; k < 3; k++) a_q[k] <= pt_rd_q[k*CW +: CW];
			cuma_q <= cum_rd_q;
		end
		if (cmd.lat_b) begin
			for (int k = 0; k < 3; k++) b_q[k] <= pt_rd_q[k*CW +: CW];
			cumb_q <= cum_rd_q;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end
		if (cmd.s_init) begin
			s_q <= total_q;
		end else if (op_s1 == pnal_pkg::MUL_SEG) begin
			s_q <= total_q - cuma_q - rnd[47:16];
		end
		if (cmd.best_load) best_q <= dist_q;

		if (cmd.acc_clr) begin
			pos_q <= '0;
			neg_q <= '0;
			den_q <= '0;
			dist_q <= '0;
		end else begin
			if (cmd.dist_clr) dist_q <= '0;
			case (op_s1)
				pnal_pkg::MUL_SQ_CA, pnal_pkg::MUL_PP: dist_q <= dist_q + prod_s1[63:0];
				pnal_pkg::MUL_DE: begin
					if (neg_s1) begin
						neg_q <= neg_q + prod_s1[63:0];
					end else begin
						pos_q <= pos_q + prod_s1[63:0];
					end
				end
				pnal_pkg::MUL_DD: den_q <= den_q + prod_s1[63:0];
				pnal_pkg::MUL_DA: pm_q[k_s1] <= MW'(evm);
				default: ;
			endcase
		end

		if (cmd.div_init) begin
			quo_q <= '0;
			rem_q <= num;
			if (den_q == '0 || pos_q <= neg_q) begin
				al_q <= '0;
				div_need_q <= 1'b0;
			end else if (num >= den_q) begin
				al_q <= 17'(pnal_pkg::AlphaOne);
				div_need_q <= 1'b0;
			end else begin
				al_q <= '0;
				div_need_q <= 1'b1;
			end
		end else if (cmd.div_step) begin
			rem_q <= quo_n[0] ? rem2 - den_q : rem2;
			quo_q <= quo_n;
			al_q <= {1'b0, quo_n};
		end

		if (cmd.sq_init) begin
			sq_v_q <= dist_q;
			sq_res_q <= '0;
			sq_bit_q <= 64'd1 << 62;
		end else if (cmd.sq_step) begin
			if (sq_v_q >= sq_t) begin
				sq_v_q <= sq_v_q - sq_t;
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end

		if (cmd.emit) begin
			out_arc_q <= cmd.emit_arc ? s_q : 32'd0;
			out_status_q <= cmd.code;
		end
	end

endmodule

>>> rtl/polyline_nearest_arc_length_core.sv
`timescale 1ns / 1ps
// polyline_nearest_arc_length_core: top level joining controller and datapath
// load: time to result set by the 32-step square root, skipped for the first point or full
// store; query: time set per segment by the shared multiplier and the 16-step divider;
// empty store skips both; one request at a time, controller returns to idle between requests
// reset clears point count, total length and control; memories are not cleared
// depends on pnal_pkg, pnal_item_if, pnal_result_if, pnal_ctrl, pnal_dp

module polyline_nearest_arc_length_core #(
	parameter int MAX_POINTS  = 256,
	parameter int COORD_WIDTH = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	pnal_item_if.sink     item,
	pnal_result_if.source result
);

	pnal_pkg::cmd_t cmd;
	pnal_pkg::sts_t sts;

	pnal_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.sts          (sts),
		.cmd          (cmd)
	);

	pnal_dp #(
		.MAX_POINTS  (MAX_POINTS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.kind       (item.kind),
		.restart    (item.restart),
		.x          (item.x),
		.y          (item.y),
		.z          (item.z),
		.cmd        (cmd),
		.sts        (sts),
		.arc_length (result.arc_length),
		.status     (result.status)
	);

endmodule
